// ===== sv/decimal_triple_record_parser_unit_macros.svh =====
// Assertion macros for the record parser.
`ifndef DECIMAL_TRIPLE_RECORD_PARSER_UNIT_MACROS_SVH
`define DECIMAL_TRIPLE_RECORD_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define DTRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dtrp assertion failed");
`define DTRP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dtrp assertion failed");
`else
`define DTRP_ASSERT(lbl, clk, rst_n, prop)
`define DTRP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/dtrp_pkg.sv =====
package dtrp_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned AMOUNT_BITS = 31;

  localparam logic [1:0] FIELD_SOURCE = 2'd0;
  localparam logic [1:0] FIELD_DEST   = 2'd1;
  localparam logic [1:0] FIELD_AMOUNT = 2'd2;
  localparam logic [1:0] FIELD_EXTRA  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } word_t;

endpackage

// ===== sv/decimal_triple_record_parser_unit.sv =====
// Parses a byte stream of text lines, each holding up to three unsigned decimal
// numbers (source, destination, amount) separated by any non-digit bytes; fields
// past the third are ignored. On newline a record word is issued when the amount
// lies in 1 to 2^31-1, and all fields are cleared. Accumulators are VALUE_BITS wide
// and wrap; ids are issued in their low 32 bits. The block takes one byte per
// cycle unless stalled: a byte is held in the input register, then folded into
// the field accumulator, whose single shift-and-add update per cycle sets that
// rate. A record is loaded into the output register at the edge that takes its
// newline from the input register, if the output is free or draining; a waiting
// record stalls the input only when the next newline would issue another one.
`include "decimal_triple_record_parser_unit_macros.svh"

module decimal_triple_record_parser_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       in_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dtrp_pkg::ID_BITS-1:0]     source_id_o,
  output logic [dtrp_pkg::ID_BITS-1:0]     dest_id_o,
  output logic [dtrp_pkg::AMOUNT_BITS-1:0] amount_o
);

  dtrp_pkg::word_t word;
  logic            take;
  logic            take_nl;

  dtrp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .take_i     (take),
    .word_o     (word)
  );

  dtrp_parse_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .source_id_o (source_id_o),
    .dest_id_o   (dest_id_o),
    .amount_o    (amount_o)
  );

  assign take_nl = take && (word.data == dtrp_pkg::CH_NEWLINE);

  `DTRP_ASSERT(a_rec_after_newline, clk_i, rst_ni, $rose(out_valid_o) |-> $past(take_nl))
  `DTRP_ASSERT(a_stall_only_when_held, clk_i, rst_ni, in_stall_o |-> word.valid)
  `DTRP_ASSERT_ALWAYS(a_amount_nonzero, clk_i, out_valid_o |-> (amount_o != '0))

endmodule

// ===== sv/dtrp_in_reg.sv =====
module dtrp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  output logic           in_stall_o,
  input  logic           take_i,
  output dtrp_pkg::word_t word_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// ===== sv/dtrp_parse_core.sv =====
module dtrp_parse_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dtrp_pkg::word_t                  word_i,
  output logic                             take_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dtrp_pkg::ID_BITS-1:0]     source_id_o,
  output logic [dtrp_pkg::ID_BITS-1:0]     dest_id_o,
  output logic [dtrp_pkg::AMOUNT_BITS-1:0] amount_o
);

  logic [VALUE_BITS-1:0] first_q, first_d;
  logic [VALUE_BITS-1:0] second_q, second_d;
  logic [VALUE_BITS-1:0] third_q, third_d;
  logic [1:0]            field_q, field_d;
  logic                  inside_q, inside_d;

  logic                  is_digit;
  logic                  is_newline;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] sel_value;
  logic [VALUE_BITS-1:0] acc_value;
  logic [63:0]           first_w, second_w, third_w;
  logic                  amount_ok;
  logic                  emit;

  logic                             out_valid_q, out_valid_d;
  logic [dtrp_pkg::ID_BITS-1:0]     source_q;
  logic [dtrp_pkg::ID_BITS-1:0]     dest_q;
  logic [dtrp_pkg::AMOUNT_BITS-1:0] amount_q;

  assign is_digit   = (word_i.data >= dtrp_pkg::CH_ZERO) && (word_i.data <= dtrp_pkg::CH_NINE);
  assign is_newline = (word_i.data == dtrp_pkg::CH_NEWLINE);
  assign digit      = word_i.data[3:0];

  always_comb begin
    case (field_q)
      dtrp_pkg::FIELD_SOURCE: sel_value = first_q;
      dtrp_pkg::FIELD_DEST:   sel_value = second_q;
      dtrp_pkg::FIELD_AMOUNT: sel_value = third_q;
      default:                sel_value = '0;
    endcase
  end

  // x10 as shift-and-add, wrapped to the accumulator width
  assign acc_value = (sel_value << 3) + (sel_value << 1) + VALUE_BITS'(digit);

  assign first_w   = 64'(first_q);
  assign second_w  = 64'(second_q);
  assign third_w   = 64'(third_q);
  assign amount_ok = (third_w != 64'd0) && (third_w[63:dtrp_pkg::AMOUNT_BITS] == '0);

  assign emit   = !is_digit && is_newline && amount_ok;
  assign take_o = word_i.valid && (!emit || !out_valid_q || !out_stall_i);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    field_d  = field_q;
    inside_d = inside_q;
    if (is_digit) begin
      case (field_q)
        dtrp_pkg::FIELD_SOURCE: first_d  = acc_value;
        dtrp_pkg::FIELD_DEST:   second_d = acc_value;
        dtrp_pkg::FIELD_AMOUNT: third_d  = acc_value;
        default: ;
      endcase
      inside_d = 1'b1;
    end else begin
      if (inside_q && (field_q != dtrp_pkg::FIELD_EXTRA)) begin
        field_d = field_q + 2'd1;
      end
      inside_d = 1'b0;
      if (is_newline) begin
        first_d  = '0;
        second_d = '0;
        third_d  = '0;
        field_d  = dtrp_pkg::FIELD_SOURCE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
      field_q  <= dtrp_pkg::FIELD_SOURCE;
      inside_q <= 1'b0;
    end else if (take_o) begin
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      field_q  <= field_d;
      inside_q <= inside_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      source_q <= first_w[dtrp_pkg::ID_BITS-1:0];
      dest_q   <= second_w[dtrp_pkg::ID_BITS-1:0];
      amount_q <= third_w[dtrp_pkg::AMOUNT_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign source_id_o = source_q;
  assign dest_id_o   = dest_q;
  assign amount_o    = amount_q;

endmodule
